[rtl/assert_macros.svh]
// Concurrent assertion wrappers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rstn, prop, msg)

`define ASSERT_CLK_ALWAYS(label, clk, prop, msg)

`endif

`endif

[rtl/srrw_pkg.sv]
package srrw_pkg;

    localparam int SEQ_W    = 31;
    localparam int HANDLE_W = 16;
    localparam int ACK_W    = 32;

    localparam logic signed [ACK_W-1:0] ACK_DONE = -32'sd2;

    typedef enum logic [1:0] {
        KIND_DELIVER = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_CUM     = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_DONE_ACK
    } eng_state_t;

    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic                fin;
        logic [HANDLE_W-1:0] handle;
    } desc_t;

    typedef struct packed {
        kind_t                     kind;
        logic [HANDLE_W-1:0]       handle;
        logic signed [ACK_W-1:0]   ack;
        logic                      last;
    } result_t;

endpackage

[rtl/srrw_desc_fifo.sv]
`include "assert_macros.svh"

module srrw_desc_fifo
    import srrw_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  desc_t push_desc,
    output logic  pop_valid,
    input  logic  pop_ready,
    output desc_t pop_desc
);

    desc_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_desc   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    `ASSERT_CLK(a_count_bound, aclk, aresetn, count_reg != 2'd3, "queue count out of range")
    `ASSERT_CLK(a_ptr_gap, aclk, aresetn, (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg), "queue pointers disagree with count")

endmodule

[rtl/srrw_engine.sv]
`include "assert_macros.svh"

module srrw_engine
    import srrw_pkg::*;
#(
    parameter int WINDOW_SLOTS = 16
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    desc_valid,
    output logic    desc_ready,
    input  desc_t   desc,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int IW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

    eng_state_t state_reg, state_next;

    logic [SEQ_W-1:0]    base_reg, base_next;
    logic [IW-1:0]       base_idx_reg, base_idx_next;
    logic [WINDOW_SLOTS-1:0] filled_reg, filled_next;
    logic [WINDOW_SLOTS-1:0] slot_final_reg;
    logic [HANDLE_W-1:0] slot_handle_reg [WINDOW_SLOTS];

    logic        res_valid_reg, res_valid_next;
    result_t     res_reg;

    logic [ACK_W-1:0] offset;
    logic             in_window;
    logic [IW:0]      idx_sum;
    logic [IW-1:0]    wr_idx;
    logic             slot_wr;
    logic             drain_adv;
    logic             emit;
    logic             out_free;
    logic             out_load;
    logic             head_filled;
    result_t          res_new;

    assign out_free    = !res_valid_reg || res_ready;
    assign out_load    = emit && out_free;
    assign head_filled = filled_reg[base_idx_reg];

    assign offset    = {1'b0, desc.seq} - {1'b0, base_reg};
    assign in_window = !offset[ACK_W-1] && (offset < ACK_W'(WINDOW_SLOTS));
    assign idx_sum   = {1'b0, base_idx_reg} + {1'b0, offset[IW-1:0]};
    assign wr_idx    = (idx_sum >= (IW+1)'(WINDOW_SLOTS))
                     ? IW'(idx_sum - (IW+1)'(WINDOW_SLOTS)) : idx_sum[IW-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (desc_valid) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    if (!head_filled) begin
                        state_next = ST_IDLE;
                    end else if (slot_final_reg[base_idx_reg]) begin
                        state_next = ST_DONE_ACK;
                    end
                end
            end
            ST_DONE_ACK: begin
                if (out_free) begin
                    state_next = ST_DRAIN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        desc_ready = 1'b0;
        slot_wr    = 1'b0;
        drain_adv  = 1'b0;
        emit       = 1'b0;
        res_new    = '{kind: KIND_CUM, handle: '0, ack: '0, last: 1'b0};
        unique case (state_reg)
            ST_IDLE: begin
                desc_ready = 1'b1;
                slot_wr    = desc_valid && in_window;
            end
            ST_DRAIN: begin
                emit = 1'b1;
                if (head_filled) begin
                    res_new.kind   = KIND_DELIVER;
                    res_new.handle = slot_handle_reg[base_idx_reg];
                    drain_adv      = out_free;
                end else begin
                    res_new.kind = KIND_CUM;
                    res_new.ack  = $signed({1'b0, base_reg} - ACK_W'(1));
                    res_new.last = 1'b1;
                end
            end
            ST_DONE_ACK: begin
                emit         = 1'b1;
                res_new.kind = KIND_DONE;
                res_new.ack  = ACK_DONE;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        base_next     = base_reg;
        base_idx_next = base_idx_reg;
        filled_next   = filled_reg;
        if (slot_wr) begin
            filled_next[wr_idx] = 1'b1;
        end
        if (drain_adv) begin
            filled_next[base_idx_reg] = 1'b0;
            base_next = base_reg + SEQ_W'(1);
            if (base_reg == '1 || base_idx_reg == IW'(WINDOW_SLOTS - 1)) begin
                base_idx_next = '0;
            end else begin
                base_idx_next = base_idx_reg + IW'(1);
            end
        end
        res_valid_next = out_load ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            base_reg      <= '0;
            base_idx_reg  <= '0;
            filled_reg    <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            base_idx_reg  <= base_idx_next;
            filled_reg    <= filled_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_wr) begin
            slot_handle_reg[wr_idx] <= desc.handle;
            slot_final_reg[wr_idx]  <= desc.fin;
        end
        if (out_load) begin
            res_reg <= res_new;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `ASSERT_CLK(a_base_idx_range, aclk, aresetn, int'(base_idx_reg) < WINDOW_SLOTS, "base slot index out of range")
    `ASSERT_CLK(a_idle_head_clear, aclk, aresetn, (state_reg == ST_IDLE) |-> !head_filled, "slot at base left filled after drain")
    `ASSERT_CLK(a_cum_ends_run, aclk, aresetn, (out_load && res_new.kind == KIND_CUM) |=> (state_reg == ST_IDLE), "cumulative ack did not end the run")

endmodule

[rtl/selective_repeat_receive_window.sv]
// An accepted transfer passes the descriptor queue and the engine's state register; its
// results leave the engine's output register, one per cycle while m_tready is high. An
// item draining k slots, f final, yields k deliveries, f done acks and a cumulative ack.
// A 2-entry descriptor queue lets input transfers continue while the engine drains.
// Reset (aresetn low, synchronous): window base zero, all slot filled bits cleared at once,
// queue and output emptied; stored slot handles are not cleared.
module selective_repeat_receive_window
    import srrw_pkg::*;
#(
    parameter int WINDOW_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // seq_number[30:0], payload_handle[46:31], zero pad[47]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // delivered_handle[15:0], ack_value[47:16]
    output logic [1:0]  m_tuser,   // result_kind[1:0]
    output logic        m_tlast
);

    desc_t   in_desc;
    desc_t   q_desc;
    logic    q_valid, q_ready;
    result_t res;

    assign in_desc.seq    = s_tdata[30:0];
    assign in_desc.fin    = s_tlast;
    assign in_desc.handle = s_tdata[46:31];

    srrw_desc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_desc  (in_desc),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_desc   (q_desc)
    );

    srrw_engine #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc_valid (q_valid),
        .desc_ready (q_ready),
        .desc       (q_desc),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {res.ack, res.handle};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule
